/* hdl/arpdc_pkg.sv */
// ----------------------------------------------------------------------------
// arpdc_pkg
// Shared types and constants for the ARP dialog classifier/tracker.
// ----------------------------------------------------------------------------
package arpdc_pkg;

  localparam int DLG_ENTRIES = 64;
  localparam int ASK_ENTRIES = 256;
  localparam int DLG_AW = (DLG_ENTRIES > 1) ? $clog2(DLG_ENTRIES) : 1;
  localparam int DLG_CW = $clog2(DLG_ENTRIES + 1);
  localparam int ASK_AW = (ASK_ENTRIES > 1) ? $clog2(ASK_ENTRIES) : 1;
  localparam int ASK_CW = $clog2(ASK_ENTRIES + 1);

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;

  localparam logic [15:0]      ETH_ARP   = 16'h0806;
  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};
  localparam logic [MAC_W-1:0] MAC_ZERO  = '0;

  localparam logic [2:0] FREE_CODE_A = 3'd3;
  localparam logic [2:0] FREE_CODE_B = 3'd4;

  // depth must be a power of two: the pointers wrap freely
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    VERD_NOT_ARP  = 3'd0,
    VERD_PROBE    = 3'd1,
    VERD_DUP      = 3'd2,
    VERD_STORED   = 3'd3,
    VERD_FULL     = 3'd4,
    VERD_RELEASED = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    DST_STORE    = 2'd0,
    DST_VERIFY   = 2'd1,
    DST_MISMATCH = 2'd2
  } dstate_t;

  typedef enum logic [1:0] {
    AST_FOUND    = 2'd0,
    AST_INSERTED = 2'd1,
    AST_FULL     = 2'd2,
    AST_NONE     = 2'd3
  } astat_t;

  typedef enum logic [1:0] {
    OP_EMIT    = 2'd0,
    OP_FRAME   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_DSCAN = 3'd1,
    S_DDONE = 3'd2,
    S_ASCAN = 3'd3,
    S_ADONE = 3'd4,
    S_OUT   = 3'd5
  } bstate_t;

  typedef struct packed {
    op_t              op;
    verdict_t         verdict;
    logic             warn;
    dstate_t          st;
    logic             req;
    logic             mism;
    logic             consistent;
    logic [MAC_W-1:0] esrc;
    logic [MAC_W-1:0] edst;
    logic [MAC_W-1:0] sha;
    logic [MAC_W-1:0] tha;
    logic [IP_W-1:0]  spa;
    logic [IP_W-1:0]  tpa;
    logic [5:0]       ridx;
    logic [2:0]       rcode;
  } item_t;

  typedef struct packed {
    logic [MAC_W-1:0] esrc;
    logic [MAC_W-1:0] edst;
    logic [MAC_W-1:0] sha;
    logic [MAC_W-1:0] tha;
    logic [IP_W-1:0]  spa;
    logic [IP_W-1:0]  tpa;
  } dlg_ent_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } ask_ent_t;

endpackage

/* hdl/arpdc_front.sv */
// ----------------------------------------------------------------------------
// arpdc_front
// Accepts items and classifies ARP frames into an item for the back end.
// ----------------------------------------------------------------------------
module arpdc_front
  import arpdc_pkg::*;
(
  input  logic             start,
  output logic             busy,
  input  logic             q_full,
  output logic             push,
  output item_t            push_item,
  input  logic             in_kind,
  input  logic [15:0]      in_ether_type,
  input  logic [MAC_W-1:0] in_eth_source_mac,
  input  logic [MAC_W-1:0] in_eth_dest_mac,
  input  logic [MAC_W-1:0] in_sender_hw_addr,
  input  logic [MAC_W-1:0] in_target_hw_addr,
  input  logic [IP_W-1:0]  in_sender_proto_addr,
  input  logic [IP_W-1:0]  in_target_proto_addr,
  input  logic [5:0]       in_release_index,
  input  logic [2:0]       in_release_code
);

  logic src_eq;

  assign busy   = q_full;
  assign push   = start & ~q_full;
  assign src_eq = (in_eth_source_mac == in_sender_hw_addr);

  always_comb begin
    push_item            = '0;
    push_item.esrc       = in_eth_source_mac;
    push_item.edst       = in_eth_dest_mac;
    push_item.sha        = in_sender_hw_addr;
    push_item.tha        = in_target_hw_addr;
    push_item.spa        = in_sender_proto_addr;
    push_item.tpa        = in_target_proto_addr;
    push_item.ridx       = in_release_index;
    push_item.rcode      = in_release_code;
    push_item.op         = OP_FRAME;
    push_item.verdict    = VERD_NOT_ARP;
    push_item.warn       = 1'b0;
    push_item.st         = DST_STORE;
    push_item.req        = 1'b0;
    push_item.mism       = 1'b0;
    push_item.consistent = 1'b0;
    if (in_kind) begin
      push_item.op      = OP_RELEASE;
      push_item.verdict = VERD_RELEASED;
    end else if (in_ether_type != ETH_ARP) begin
      push_item.op = OP_EMIT;
    end else begin
      push_item.mism       = ~src_eq;
      push_item.consistent = src_eq;
      if (in_eth_dest_mac != in_target_hw_addr) begin
        if (in_eth_dest_mac == MAC_BCAST) begin
          if (in_target_hw_addr == MAC_ZERO) begin
            push_item.req = 1'b1;
            push_item.st  = DST_VERIFY;
          end else begin
            push_item.warn = 1'b1;
          end
        end else begin
          push_item.warn       = 1'b1;
          push_item.consistent = 1'b0;
          // unicast with zero target: access point probe, dropped
          if (in_target_hw_addr == MAC_ZERO) begin
            push_item.op      = OP_EMIT;
            push_item.verdict = VERD_PROBE;
          end
        end
      end else if (src_eq) begin
        push_item.st = DST_VERIFY;
      end else begin
        push_item.warn = 1'b1;
        push_item.st   = DST_MISMATCH;
      end
    end
  end

endmodule

/* hdl/arpdc_queue.sv */
// ----------------------------------------------------------------------------
// arpdc_queue
// Two-entry queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module arpdc_queue
  import arpdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t head
);

  item_t           mem_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;

  assign full  = (cnt_r == Q_CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* hdl/arpdc_back.sv */
// ----------------------------------------------------------------------------
// arpdc_back
// Table engine: frees dialog entries on release; for ARP frames scans the dialog table,
// stores unless a duplicate was found, then scans the asker table.
module arpdc_back
  import arpdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  item_t      head,
  output logic       pop,
  output logic       out_valid,
  output logic [2:0] out_verdict,
  output logic       out_is_warning,
  output logic [1:0] out_dialog_state,
  output logic       out_is_request,
  output logic       out_source_mismatch,
  output logic [5:0] out_dialog_index,
  output logic [1:0] out_asker_status,
  output logic [7:0] out_asker_index
);

  bstate_t state_r, state_nxt;
  item_t   cur_r;

  dlg_ent_t dmem [DLG_ENTRIES];
  dlg_ent_t drd_r;
  ask_ent_t amem [ASK_ENTRIES];
  ask_ent_t ard_r;

  logic [DLG_ENTRIES-1:0] dfree_r;
  logic [DLG_CW-1:0]      dcnt_r;
  logic [DLG_CW-1:0]      d_addr_r;
  logic                   dpend_r;
  logic [DLG_AW-1:0]      dpend_idx_r;
  logic                   dup_r;
  logic                   ffound_r;
  logic [DLG_AW-1:0]      fidx_r;
  logic [ASK_CW-1:0]      acnt_r;
  logic [ASK_CW-1:0]      a_addr_r;
  logic                   apend_r;
  logic [ASK_AW-1:0]      apend_idx_r;
  logic                   afound_r;

  verdict_t   res_verdict_r;
  logic       res_warn_r;
  dstate_t    res_st_r;
  logic       res_req_r;
  logic       res_mism_r;
  logic [5:0] res_didx_r;
  astat_t     res_astat_r;
  logic [7:0] res_aidx_r;

  logic              d_issue, d_hit, d_direct, d_cross, d_store;
  logic [DLG_AW-1:0] d_aidx;
  logic              a_issue, a_hit, a_room;
  logic              rel_ok;

  always_comb begin
    d_aidx   = d_addr_r[DLG_AW-1:0];
    d_issue  = (state_r == S_DSCAN) && (d_addr_r < DLG_CW'(DLG_ENTRIES));
    d_direct = (drd_r.esrc == cur_r.esrc) && (drd_r.spa == cur_r.spa) &&
               (drd_r.tha == cur_r.tha) && (drd_r.tpa == cur_r.tpa);
    d_cross  = !cur_r.req && (drd_r.edst == cur_r.esrc) &&
               (drd_r.tpa == cur_r.spa) && (drd_r.sha == cur_r.tha) &&
               (drd_r.spa == cur_r.tpa);
    // entries written so far form a prefix of the table, released ones included
    d_hit    = (state_r == S_DSCAN) && dpend_r && cur_r.consistent &&
               (DLG_CW'(dpend_idx_r) < dcnt_r) && (d_direct || d_cross);
    d_store  = (state_r == S_DDONE) && !dup_r && ffound_r;
    a_hit    = (state_r == S_ASCAN) && apend_r &&
               (ard_r.ip == cur_r.spa) && (ard_r.mac == cur_r.sha);
    a_issue  = (state_r == S_ASCAN) && (a_addr_r < acnt_r) && !a_hit;
    a_room   = (acnt_r < ASK_CW'(ASK_ENTRIES));
    pop      = (state_r == S_IDLE) && !q_empty;
    rel_ok   = (int'(head.ridx) < DLG_ENTRIES) &&
               ((head.rcode == FREE_CODE_A) || (head.rcode == FREE_CODE_B));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) state_nxt = (head.op == OP_FRAME) ? S_DSCAN : S_OUT;
      end
      S_DSCAN: begin
        if (!d_issue && !dpend_r) state_nxt = S_DDONE;
      end
      S_DDONE: begin
        state_nxt = dup_r ? S_OUT : S_ASCAN;
      end
      S_ASCAN: begin
        if (a_hit || (!(a_addr_r < acnt_r) && !apend_r)) state_nxt = S_ADONE;
      end
      S_ADONE: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_store) begin
      dmem[fidx_r] <= '{esrc: cur_r.esrc, edst: cur_r.edst, sha: cur_r.sha,
                        tha: cur_r.tha, spa: cur_r.spa, tpa: cur_r.tpa};
    end
    if (d_issue) drd_r <= dmem[d_aidx];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_ADONE) && !afound_r && a_room) begin
      amem[acnt_r[ASK_AW-1:0]] <= '{ip: cur_r.spa, mac: cur_r.sha};
    end
    if (a_issue) ard_r <= amem[a_addr_r[ASK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      dfree_r       <= '1;
      dcnt_r        <= '0;
      acnt_r        <= '0;
      d_addr_r      <= '0;
      dpend_r       <= 1'b0;
      dpend_idx_r   <= '0;
      dup_r         <= 1'b0;
      ffound_r      <= 1'b0;
      fidx_r        <= '0;
      a_addr_r      <= '0;
      apend_r       <= 1'b0;
      apend_idx_r   <= '0;
      afound_r      <= 1'b0;
      res_verdict_r <= VERD_NOT_ARP;
      res_warn_r    <= 1'b0;
      res_st_r      <= DST_STORE;
      res_req_r     <= 1'b0;
      res_mism_r    <= 1'b0;
      res_didx_r    <= '0;
      res_astat_r   <= AST_NONE;
      res_aidx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            d_addr_r      <= '0;
            dpend_r       <= 1'b0;
            dup_r         <= 1'b0;
            ffound_r      <= 1'b0;
            a_addr_r      <= '0;
            apend_r       <= 1'b0;
            afound_r      <= 1'b0;
            res_verdict_r <= head.verdict;
            res_warn_r    <= head.warn;
            res_st_r      <= head.st;
            res_req_r     <= head.req;
            res_mism_r    <= head.mism;
            res_didx_r    <= '0;
            res_astat_r   <= AST_NONE;
            res_aidx_r    <= '0;
            if (head.op == OP_RELEASE) begin
              res_didx_r <= head.ridx;
              if (rel_ok) dfree_r[DLG_AW'(head.ridx)] <= 1'b1;
            end
          end
        end
        S_DSCAN: begin
          if (d_issue) begin
            d_addr_r    <= d_addr_r + 1'b1;
            dpend_r     <= 1'b1;
            dpend_idx_r <= d_aidx;
            if (dfree_r[d_aidx] && !ffound_r) begin
              ffound_r <= 1'b1;
              fidx_r   <= d_aidx;
            end
          end else begin
            dpend_r <= 1'b0;
          end
          if (d_hit) dup_r <= 1'b1;
        end
        S_DDONE: begin
          if (dup_r) begin
            res_verdict_r <= VERD_DUP;
          end else if (ffound_r) begin
            dfree_r[fidx_r] <= 1'b0;
            if (DLG_CW'(fidx_r) == dcnt_r) dcnt_r <= dcnt_r + 1'b1;
            res_verdict_r <= VERD_STORED;
            res_didx_r    <= 6'(fidx_r);
          end else begin
            res_verdict_r <= VERD_FULL;
          end
        end
        S_ASCAN: begin
          if (a_hit) begin
            afound_r   <= 1'b1;
            res_aidx_r <= 8'(apend_idx_r);
            apend_r    <= 1'b0;
          end else if (a_issue) begin
            a_addr_r    <= a_addr_r + 1'b1;
            apend_r     <= 1'b1;
            apend_idx_r <= a_addr_r[ASK_AW-1:0];
          end else begin
            apend_r <= 1'b0;
          end
        end
        S_ADONE: begin
          if (afound_r) begin
            res_astat_r <= AST_FOUND;
          end else if (a_room) begin
            res_astat_r <= AST_INSERTED;
            res_aidx_r  <= 8'(acnt_r[ASK_AW-1:0]);
            acnt_r      <= acnt_r + 1'b1;
          end else begin
            res_astat_r <= AST_FULL;
            res_aidx_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid           = (state_r == S_OUT);
    out_verdict         = res_verdict_r;
    out_is_warning      = res_warn_r;
    out_dialog_state    = res_st_r;
    out_is_request      = res_req_r;
    out_source_mismatch = res_mism_r;
    out_dialog_index    = res_didx_r;
    out_asker_status    = res_astat_r;
    out_asker_index     = res_aidx_r;
  end

  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DLG_CW'(DLG_ENTRIES)) else $error("dialog fill count overflow");

  a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
    d_store |-> dfree_r[fidx_r]) else $error("store into a busy dialog entry");

  a_acnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_ADONE |=> acnt_r == $past(acnt_r))
    else $error("asker count moved outside insert step");

  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> state_r == S_IDLE) else $error("result held over");

endmodule

/* hdl/arp_dialog_classifier_tracker_core.sv */
// ----------------------------------------------------------------------------
// arp_dialog_classifier_tracker_core
// ARP frame classifier with dialog and asker table tracking.
// ----------------------------------------------------------------------------
// Order of steps: release, not-ARP and probe items go straight to the result;
//   an ARP frame first scans the dialog table (duplicates end here), then
//   scans the filled part of the asker table before its result is given.
// Throughput: one item at a time in the table engine; the two-entry queue lets
//   up to two more items be taken while it works. Results cannot be stalled.
// Reset: synchronous, active low; tables read as empty right after reset.
module arp_dialog_classifier_tracker_core
  import arpdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_kind,
  input  logic [15:0]      in_ether_type,
  input  logic [MAC_W-1:0] in_eth_source_mac,
  input  logic [MAC_W-1:0] in_eth_dest_mac,
  input  logic [MAC_W-1:0] in_sender_hw_addr,
  input  logic [MAC_W-1:0] in_target_hw_addr,
  input  logic [IP_W-1:0]  in_sender_proto_addr,
  input  logic [IP_W-1:0]  in_target_proto_addr,
  input  logic [5:0]       in_release_index,
  input  logic [2:0]       in_release_code,
  output logic             out_valid,
  output logic [2:0]       out_verdict,
  output logic             out_is_warning,
  output logic [1:0]       out_dialog_state,
  output logic             out_is_request,
  output logic             out_source_mismatch,
  output logic [5:0]       out_dialog_index,
  output logic [1:0]       out_asker_status,
  output logic [7:0]       out_asker_index
);

  logic  q_full, q_empty, push, pop;
  item_t push_item, head;

  arpdc_front u_front (
    .start                (start),
    .busy                 (busy),
    .q_full               (q_full),
    .push                 (push),
    .push_item            (push_item),
    .in_kind              (in_kind),
    .in_ether_type        (in_ether_type),
    .in_eth_source_mac    (in_eth_source_mac),
    .in_eth_dest_mac      (in_eth_dest_mac),
    .in_sender_hw_addr    (in_sender_hw_addr),
    .in_target_hw_addr    (in_target_hw_addr),
    .in_sender_proto_addr (in_sender_proto_addr),
    .in_target_proto_addr (in_target_proto_addr),
    .in_release_index     (in_release_index),
    .in_release_code      (in_release_code)
  );

  arpdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  arpdc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_verdict         (out_verdict),
    .out_is_warning      (out_is_warning),
    .out_dialog_state    (out_dialog_state),
    .out_is_request      (out_is_request),
    .out_source_mismatch (out_source_mismatch),
    .out_dialog_index    (out_dialog_index),
    .out_asker_status    (out_asker_status),
    .out_asker_index     (out_asker_index)
  );

endmodule

/* dv/arp_dialog_classifier_tracker_checker.sv */
// ----------------------------------------------------------------------------
// arp_dialog_classifier_tracker_checker
// Watches the command and result channels of the ARP dialog tracker, keeps
// its own copy of the dialog and asker tables, predicts each result and
// compares it field by field in order.
// ----------------------------------------------------------------------------
module arp_dialog_classifier_tracker_checker
  import arpdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic             in_kind,
  input  logic [15:0]      in_ether_type,
  input  logic [MAC_W-1:0] in_eth_source_mac,
  input  logic [MAC_W-1:0] in_eth_dest_mac,
  input  logic [MAC_W-1:0] in_sender_hw_addr,
  input  logic [MAC_W-1:0] in_target_hw_addr,
  input  logic [IP_W-1:0]  in_sender_proto_addr,
  input  logic [IP_W-1:0]  in_target_proto_addr,
  input  logic [5:0]       in_release_index,
  input  logic [2:0]       in_release_code,
  input  logic             out_valid,
  input  logic [2:0]       out_verdict,
  input  logic             out_is_warning,
  input  logic [1:0]       out_dialog_state,
  input  logic             out_is_request,
  input  logic             out_source_mismatch,
  input  logic [5:0]       out_dialog_index,
  input  logic [1:0]       out_asker_status,
  input  logic [7:0]       out_asker_index,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [2:0] verdict;
    logic       warn;
    logic [1:0] st;
    logic       req;
    logic       mism;
    logic [5:0] didx;
    logic [1:0] astat;
    logic [7:0] aidx;
  } arp_result_t;

  dlg_ent_t    dialog_tab [DLG_ENTRIES];
  logic [2:0]  dialog_code [DLG_ENTRIES];
  logic        dialog_used [DLG_ENTRIES];
  ask_ent_t    asker_tab [ASK_ENTRIES];
  logic        asker_used [ASK_ENTRIES];
  arp_result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic arp_result_t classify_and_track();
    arp_result_t r;
    logic [MAC_W-1:0] esrc, edst, sha, tha;
    logic [IP_W-1:0] spa, tpa;
    logic src_eq, consistent, dup, found;
    r = '0;
    r.astat = AST_NONE;
    esrc = in_eth_source_mac;  edst = in_eth_dest_mac;
    sha = in_sender_hw_addr;   tha = in_target_hw_addr;
    spa = in_sender_proto_addr; tpa = in_target_proto_addr;
    if (in_kind) begin
      if (in_release_code == FREE_CODE_A || in_release_code == FREE_CODE_B)
        dialog_code[in_release_index] = in_release_code;
      r.verdict = VERD_RELEASED;
      r.didx = in_release_index;
      return r;
    end
    if (in_ether_type != ETH_ARP) begin
      r.verdict = VERD_NOT_ARP;
      return r;
    end
    src_eq = (esrc == sha);
    r.mism = !src_eq;
    consistent = src_eq;
    r.st = DST_STORE;
    if (edst != tha) begin
      if (edst == MAC_BCAST) begin
        if (tha == MAC_ZERO) begin
          r.req = 1'b1;
          r.st = DST_VERIFY;
        end else begin
          r.warn = 1'b1;
        end
      end else begin
        // unicast probe: dropped before any table access
        if (tha == MAC_ZERO) begin
          r.verdict = VERD_PROBE;
          r.warn = 1'b1;
          return r;
        end
        r.warn = 1'b1;
        consistent = 1'b0;
      end
    end else if (src_eq) begin
      r.st = DST_VERIFY;
    end else begin
      r.warn = 1'b1;
      r.st = DST_MISMATCH;
    end
    dup = 1'b0;
    if (consistent) begin
      for (int i = 0; i < DLG_ENTRIES; i++) begin
        if (dialog_used[i]) begin
          if (dialog_tab[i].esrc == esrc && dialog_tab[i].spa == spa &&
              dialog_tab[i].tha == tha && dialog_tab[i].tpa == tpa)
            dup = 1'b1;
          else if (!r.req && dialog_tab[i].edst == esrc &&
                   dialog_tab[i].tpa == spa && dialog_tab[i].sha == tha &&
                   dialog_tab[i].spa == tpa)
            dup = 1'b1;
        end
      end
    end
    if (dup) begin
      r.verdict = VERD_DUP;
      return r;
    end
    r.verdict = VERD_FULL;
    for (int i = 0; i < DLG_ENTRIES; i++) begin
      if (dialog_code[i] == FREE_CODE_A || dialog_code[i] == FREE_CODE_B) begin
        dialog_tab[i] = '{esrc: esrc, edst: edst, sha: sha, tha: tha,
                          spa: spa, tpa: tpa};
        dialog_code[i] = {1'b0, r.st};
        dialog_used[i] = 1'b1;
        r.didx = 6'(i);
        r.verdict = VERD_STORED;
        break;
      end
    end
    found = 1'b0;
    for (int i = 0; i < ASK_ENTRIES; i++) begin
      if (asker_used[i] && asker_tab[i].ip == spa && asker_tab[i].mac == sha) begin
        found = 1'b1;
        r.aidx = 8'(i);
        r.astat = AST_FOUND;
        break;
      end
    end
    if (!found) begin
      r.astat = AST_FULL;
      for (int i = 0; i < ASK_ENTRIES; i++) begin
        if (!asker_used[i]) begin
          asker_tab[i] = '{ip: spa, mac: sha};
          asker_used[i] = 1'b1;
          r.aidx = 8'(i);
          r.astat = AST_INSERTED;
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    arp_result_t got, want;
    if (!rst_n) begin
      fail_count = 0;
      for (int i = 0; i < DLG_ENTRIES; i++) begin
        dialog_code[i] = FREE_CODE_A;
        dialog_used[i] = 1'b0;
      end
      for (int i = 0; i < ASK_ENTRIES; i++) asker_used[i] = 1'b0;
      expected_results.delete();
    end else begin
      // compare first: a result on this edge always belongs to an older beat
      if (out_valid) begin
        got = '{verdict: out_verdict, warn: out_is_warning, st: out_dialog_state,
                req: out_is_request, mism: out_source_mismatch,
                didx: out_dialog_index, astat: out_asker_status,
                aidx: out_asker_index};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("result mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (start && !busy) expected_results.push_back(classify_and_track());
    end
  end

endmodule

/* dv/arp_dialog_classifier_tracker_core_tb.sv */
// ----------------------------------------------------------------------------
// arp_dialog_classifier_tracker_core_tb
// Drives directed and random ARP and non-ARP frames and release commands into the
// tracker with random gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module arp_dialog_classifier_tracker_core_tb;
  import arpdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_kind = 1'b0;
  logic [15:0]      in_ether_type = '0;
  logic [MAC_W-1:0] in_eth_source_mac = '0;
  logic [MAC_W-1:0] in_eth_dest_mac = '0;
  logic [MAC_W-1:0] in_sender_hw_addr = '0;
  logic [MAC_W-1:0] in_target_hw_addr = '0;
  logic [IP_W-1:0]  in_sender_proto_addr = '0;
  logic [IP_W-1:0]  in_target_proto_addr = '0;
  logic [5:0]       in_release_index = '0;
  logic [2:0]       in_release_code = FREE_CODE_A;
  logic             out_valid;
  logic [2:0]       out_verdict;
  logic             out_is_warning;
  logic [1:0]       out_dialog_state;
  logic             out_is_request;
  logic             out_source_mismatch;
  logic [5:0]       out_dialog_index;
  logic [1:0]       out_asker_status;
  logic [7:0]       out_asker_index;
  int               fail_count;
  int               pending_count;
  int               quiet_cycles = 0;
  bit               no_gaps = 1'b0;

  typedef struct packed {
    logic [MAC_W-1:0] esrc, edst, sha, tha;
    logic [IP_W-1:0]  spa, tpa;
  } arp_frame_t;

  logic [MAC_W-1:0] mac_pool [6];
  logic [IP_W-1:0]  ip_pool [6];
  arp_frame_t       last_frame;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  arp_dialog_classifier_tracker_core dut (.*);
  arp_dialog_classifier_tracker_checker chk (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one beat and hold it until taken, then maybe leave a gap
  task automatic send_beat(input logic kind, input logic [15:0] etype,
                           input arp_frame_t f, input logic [5:0] ridx,
                           input logic [2:0] rcode);
    in_kind <= kind;
    in_ether_type <= etype;
    in_eth_source_mac <= f.esrc;
    in_eth_dest_mac <= f.edst;
    in_sender_hw_addr <= f.sha;
    in_target_hw_addr <= f.tha;
    in_sender_proto_addr <= f.spa;
    in_target_proto_addr <= f.tpa;
    in_release_index <= ridx;
    in_release_code <= rcode;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (kind == 1'b0) last_frame = f;
    if (!no_gaps && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input arp_frame_t f);
    send_beat(1'b0, ETH_ARP, f, 6'd0, FREE_CODE_A);
  endtask

  task automatic send_release(input logic [5:0] ridx, input logic [2:0] rcode);
    send_beat(1'b1, 16'($urandom), '{default: '0}, ridx, rcode);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  function automatic logic [MAC_W-1:0] any_mac();
    int k;
    k = $urandom_range(9);
    if (k < 6) return mac_pool[k];
    if (k == 6) return MAC_BCAST;
    if (k == 7) return MAC_ZERO;
    return rand_mac();
  endfunction

  function automatic arp_frame_t pooled_frame();
    arp_frame_t f;
    int k;
    k = $urandom_range(5);
    f.sha = mac_pool[k];
    f.spa = ip_pool[k];
    if ($urandom_range(9) == 0) f.spa = $urandom;
    f.esrc = ($urandom_range(9) < 7) ? f.sha : any_mac();
    f.tpa = ip_pool[$urandom_range(5)];
    case ($urandom_range(3))
      0: begin
        f.edst = MAC_BCAST;
        f.tha = MAC_ZERO;
      end
      1: begin
        f.tha = any_mac();
        f.edst = f.tha;
      end
      default: begin
        f.edst = any_mac();
        f.tha = any_mac();
      end
    endcase
    return f;
  endfunction

  initial begin
    arp_frame_t f, g;
    int n;
    for (int i = 0; i < 6; i++) begin
      mac_pool[i] = rand_mac();
      ip_pool[i] = $urandom;
    end
    mac_pool[0] = 48'hFFFF_FFFF_FFFE;
    ip_pool[0] = '1;
    ip_pool[1] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: not ARP, each class, probe, duplicates, releases
    f = '{esrc: mac_pool[1], edst: MAC_BCAST, sha: mac_pool[1], tha: MAC_ZERO,
          spa: ip_pool[1], tpa: ip_pool[2]};
    send_beat(1'b0, 16'h0800, f, 6'd0, FREE_CODE_A);
    send_beat(1'b0, 16'hFFFF, f, 6'd0, FREE_CODE_A);
    send_frame(f);                                   // request
    send_frame(f);                                   // direct duplicate
    g = '{esrc: mac_pool[2], edst: mac_pool[1], sha: mac_pool[2], tha: mac_pool[1],
          spa: ip_pool[2], tpa: ip_pool[1]};
    send_frame(g);                                   // reply
    send_frame('{esrc: g.edst, edst: g.sha, sha: g.edst, tha: g.sha,
                 spa: g.tpa, tpa: g.spa});           // crossed duplicate
    g.esrc = mac_pool[3];
    send_frame(g);                                   // source mismatch
    send_frame('{esrc: mac_pool[4], edst: MAC_BCAST, sha: mac_pool[4],
                 tha: mac_pool[5], spa: ip_pool[4], tpa: ip_pool[5]});
    send_frame('{esrc: mac_pool[4], edst: mac_pool[5], sha: mac_pool[4],
                 tha: MAC_ZERO, spa: ip_pool[4], tpa: ip_pool[5]});   // probe
    send_frame('{esrc: mac_pool[4], edst: mac_pool[5], sha: mac_pool[4],
                 tha: mac_pool[3], spa: ip_pool[4], tpa: ip_pool[5]});
    send_frame('{esrc: '1, edst: '1, sha: '1, tha: '1, spa: '1, tpa: '1});
    send_frame('{esrc: '0, edst: '0, sha: '0, tha: '0, spa: '0, tpa: '0});
    send_release(6'd0, FREE_CODE_B);
    send_release(6'd63, FREE_CODE_A);
    send_frame(f);                                   // released entry still matches
    send_frame(pooled_frame());

    // fill the asker table with distinct senders; dialog runs full too
    for (n = 0; n < 270; n++) begin
      if ($urandom_range(19) == 0)
        send_release(6'($urandom), $urandom_range(1) ? FREE_CODE_A : FREE_CODE_B);
      f.sha = 48'h0200_0000_0000 + n;
      f.esrc = f.sha;
      f.spa = 32'h0A00_0000 + n;
      f.tha = rand_mac();
      f.edst = f.tha;
      f.tpa = $urandom;
      send_frame(f);
    end

    // let the tables settle before the random part
    start <= 1'b0;
    wait (pending_count == 0);
    @(posedge clk);

    for (n = 0; n < 560; n++) begin
      no_gaps = (n >= 150 && n < 300);
      case ($urandom_range(19))
        0, 1, 2: send_release(6'($urandom), $urandom_range(1) ? FREE_CODE_A : FREE_CODE_B);
        3: send_beat(1'b0, 16'($urandom), pooled_frame(), 6'd0, FREE_CODE_A);
        4, 5: send_frame(last_frame);
        6, 7: send_frame('{esrc: last_frame.edst, edst: last_frame.sha,
                           sha: last_frame.edst, tha: last_frame.sha,
                           spa: last_frame.tpa, tpa: last_frame.spa});
        8: send_frame('{esrc: rand_mac(), edst: rand_mac(),
                        sha: rand_mac(), tha: rand_mac(),
                        spa: $urandom, tpa: $urandom});
        default: send_frame(pooled_frame());
      endcase
    end
    start <= 1'b0;

    wait (pending_count == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
